/* rtl/core/ctsm_pkg.sv */
// Shared constants, codes and helpers for the category time share monitor.
// No dependencies; imported by the top level and its port checker.
package ctsm_pkg;

	// Number of tracked categories and derived index width
	localparam int NUM_CATEGORIES = 16;
	localparam int IDX_W          = $clog2(NUM_CATEGORIES);

	// Field widths
	localparam int KIND_W = 2;
	localparam int CAT_W  = 4;
	localparam int TIME_W = 32;
	localparam int PCT_W  = 7;
	localparam int CIU_W  = 5;
	localparam int CFG_W  = 5;
	localparam int CIDX_W = 1;

	// Width that holds both the category limit and categories_in_use
	localparam int LIM_W = ($clog2(NUM_CATEGORIES + 1) > CIU_W) ?
		$clog2(NUM_CATEGORIES + 1) : CIU_W;

	// Dividend width: a time value scaled by one hundred
	localparam int NUM_W = TIME_W + PCT_W;
	localparam int CNT_W = $clog2(NUM_W);

	localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
	localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(NUM_CATEGORIES);

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_SWITCH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_CATS_IN_USE = 1'b0;
	localparam logic [CIDX_W-1:0] REG_INIT_CAT    = 1'b1;

	// Saturating add of two time values
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

/* rtl/core/category_time_share_monitor.sv */
// Category time share monitor: accumulators, control sequencer and serial divider.
// Depends on ctsm_pkg.
//
// Usage:
//   Items enter on start/kind/category/now_ms and are taken when start is high
//   and busy is low. One result beat per item leaves on done with percent,
//   current_category and bad_category, valid for that one cycle only; the
//   receiver cannot stall, so nothing is held back.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is high while the block is idle.
// Sequence (accept edge to done cycle):
//   switch, clear, restart, rejected items and queries on a zero total: READ, ACC.
//   Query: READ, ACC, MUL, DIV, FIN. The restoring divider retires one
//   quotient bit per cycle over the 39-bit scaled dividend in DIV.
// Throughput: one item at a time; a new item may be accepted in the cycle that
//   shows done.
// Reset: all accumulators and the total read as zero, start stamp zero, the
//   current category is 0, categories_in_use is 16. Per-entry valid bits clear
//   at once, so no clearing pass is needed.
module category_time_share_monitor
	import ctsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [KIND_W-1:0] kind,
	input  logic [CAT_W-1:0]  category,
	input  logic [TIME_W-1:0] now_ms,
	output logic              done,
	output logic [PCT_W-1:0]  percent,
	output logic [CAT_W-1:0]  current_category,
	output logic              bad_category,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]          state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [CAT_W-1:0]    cat_q;
	logic [TIME_W-1:0]   now_q;
	logic [CAT_W-1:0]    active_q;
	logic [CIU_W-1:0]    ciu_q;
	logic [TIME_W-1:0]   stamp_q;
	logic [TIME_W-1:0]   total_q;
	logic [NUM_CATEGORIES-1:0] vld_q;

	logic [TIME_W-1:0]   mem_q [NUM_CATEGORIES];
	logic [TIME_W-1:0]   rd_a_q;
	logic [TIME_W-1:0]   rd_b_q;
	logic                rd_a_vld_q;
	logic                rd_b_vld_q;

	logic [NUM_W-1:0]    num_q;
	logic [TIME_W-1:0]   den_q;
	logic [TIME_W-1:0]   rem_q;
	logic [PCT_W-1:0]    quo_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                done_q;
	logic [PCT_W-1:0]    percent_q;
	logic [CAT_W-1:0]    cur_q;
	logic                bad_q;

	logic                accept;
	logic                cfg_wr;
	logic [TIME_W-1:0]   delta;
	logic [TIME_W-1:0]   acc_a;
	logic [TIME_W-1:0]   acc_b;
	logic [TIME_W-1:0]   new_a;
	logic [TIME_W-1:0]   new_t;
	logic [TIME_W-1:0]   share;
	logic [LIM_W-1:0]    limit;
	logic                cat_ok;
	logic                act_ok;
	logic                is_sq;
	logic                acc_en;
	logic [TIME_W:0]     trial;
	logic                qbit;
	logic [IDX_W-1:0]    act_idx;
	logic [IDX_W-1:0]    cat_idx;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign act_idx = active_q[IDX_W-1:0];
	assign cat_idx = cat_q[IDX_W-1:0];

	// Accumulation terms for the item under work
	always_comb begin
		delta  = now_q - stamp_q;
		acc_a  = rd_a_vld_q ? rd_a_q : '0;
		acc_b  = rd_b_vld_q ? rd_b_q : '0;
		new_a  = sat_add(acc_a, delta);
		new_t  = sat_add(total_q, delta);
		limit  = (LIM_W'(ciu_q) > LIM_MAX) ? LIM_MAX : LIM_W'(ciu_q);
		cat_ok = (LIM_W'(cat_q) < limit);
		act_ok = (LIM_W'(active_q) < LIM_MAX);
		is_sq  = (kind_q == KIND_SWITCH) || (kind_q == KIND_QUERY);
		acc_en = is_sq && cat_ok;
		share  = (act_ok && (cat_idx == act_idx)) ? new_a : acc_b;
	end

	// One restoring divide step
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]} - {1'b0, den_q};
		qbit  = !trial[TIME_W];
	end

	// Accumulator store: written at the current category, read at two places
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC && acc_en && act_ok) begin
			mem_q[act_idx] <= new_a;
		end
		rd_a_q <= mem_q[act_idx];
		rd_b_q <= mem_q[cat_idx];
	end

	// Sequencer, configuration and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			active_q   <= '0;
			ciu_q      <= CIU_W'(NUM_CATEGORIES);
			stamp_q    <= '0;
			total_q    <= '0;
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Take register writes while idle
			if (cfg_wr) begin
				case (cfg_index)
					REG_CATS_IN_USE: ciu_q <= cfg_data;
					REG_INIT_CAT: begin
						if (LIM_W'(cfg_data[CAT_W-1:0]) < LIM_MAX) begin
							active_q <= cfg_data[CAT_W-1:0];
						end
					end
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					rd_a_vld_q <= vld_q[act_idx];
					rd_b_vld_q <= vld_q[cat_idx];
					state_q    <= ST_ACC;
				end
				ST_ACC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (acc_en) begin
						if (act_ok) begin
							vld_q[act_idx] <= 1'b1;
						end
						total_q <= new_t;
						stamp_q <= now_q;
						if (kind_q == KIND_SWITCH) begin
							active_q <= cat_q;
						end else if (new_t != '0) begin
							// Hand the query to the divider
							state_q <= ST_MUL;
							done_q  <= 1'b0;
						end
					end else if (kind_q == KIND_CLEAR) begin
						vld_q   <= '0;
						total_q <= '0;
					end else if (kind_q == KIND_RESTART) begin
						stamp_q <= now_q;
					end
				end
				ST_MUL: begin
					cnt_q   <= CNT_W'(NUM_W - 1);
					ovf_q   <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					ovf_q <= ovf_q | quo_q[PCT_W-1];
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item, divider and result payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			cat_q  <= category;
			now_q  <= now_ms;
		end
		case (state_q)
			ST_ACC: begin
				num_q     <= {{PCT_W{1'b0}}, share};
				den_q     <= new_t;
				rem_q     <= '0;
				quo_q     <= '0;
				percent_q <= '0;
				bad_q     <= is_sq && !cat_ok;
				cur_q     <= (acc_en && kind_q == KIND_SWITCH) ? cat_q : active_q;
			end
			ST_MUL: begin
				// Scale by one hundred: 64 + 32 + 4
				num_q <= (num_q << 6) + (num_q << 5) + (num_q << 2);
			end
			ST_DIV: begin
				// Shift in one dividend bit, retire one quotient bit
				num_q <= num_q << 1;
				rem_q <= qbit ? trial[TIME_W-1:0] : {rem_q[TIME_W-2:0], num_q[NUM_W-1]};
				quo_q <= {quo_q[PCT_W-2:0], qbit};
			end
			ST_FIN: begin
				percent_q <= (ovf_q || quo_q > PCT_MAX) ? PCT_MAX : quo_q;
			end
			default: ;
		endcase
	end

	assign done             = done_q;
	assign percent          = percent_q;
	assign current_category = cur_q;
	assign bad_category     = bad_q;

endmodule

/* rtl/core/ctsm_checker.sv */
// Port-level checker for the category time share monitor, with its bind.
// Depends on ctsm_pkg and the top level's port list.
module ctsm_checker
	import ctsm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [PCT_W-1:0]  percent,
	input logic              bad_category
);

	// Reported share never exceeds one hundred
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (percent <= PCT_MAX))
		else $error("percent above 100");

	// A rejected item carries no share
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_category) |-> (percent == '0))
		else $error("rejected item with nonzero percent");

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// Result beats are never back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

endmodule

bind category_time_share_monitor ctsm_checker u_ctsm_checker (.*);
